// ===== hw/rtl/lgn_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the loudness gain normalizer.
package lgn_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 28;
    localparam int CORR_W   = 13;
    localparam int LOUD_W   = 16;
    localparam int ROOT_N   = 24;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [GAIN_W-1:0]   t_gain;
    typedef logic signed [CORR_W-1:0]   t_corr;
    typedef logic signed [LOUD_W-1:0]   t_loud;

    localparam t_gain UNITY_Q24        = 28'd16777216;
    localparam t_gain GAIN_MAX         = 28'd268435455;
    localparam logic [23:0] LOG2_10_STEP = 24'd11146541;
    localparam t_loud INVALID_LOUDNESS = -16'sd12800;

    // Floor integer square root, used only for building the root table.
    function automatic logic [63:0] lgn_isqrt(input logic [63:0] x);
        logic [63:0] xv;
        logic [63:0] r;
        logic [63:0] b;
        xv = x;
        r  = '0;
        b  = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b > xv) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (xv >= r + b) begin
                    xv = xv - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Root 2^(2^-k) in Q2.30, each the floor square root of the one before.
    function automatic logic [31:0] lgn_root(input int k);
        logic [63:0] root;
        root = 64'h0000_0000_8000_0000;
        for (int i = 1; i <= ROOT_N; i++) begin
            if (i <= k) begin
                root = lgn_isqrt(root << 30);
            end
        end
        return root[31:0];
    endfunction

endpackage

// ===== hw/rtl/lgn_lane.sv =====
// One scaling lane: sample times gain, round half up, saturate to 24 bits.
module lgn_lane (
    input  logic             i_clk,
    input  logic             i_load,
    input  lgn_pkg::t_sample i_sample,
    input  lgn_pkg::t_gain   i_gain,
    output lgn_pkg::t_sample o_scaled
);
    import lgn_pkg::*;

    logic signed [52:0] r_prod;
    logic signed [53:0] w_sum;
    logic signed [29:0] w_y;

    // Hold the product until the merge stage takes it.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= 53'(i_sample) * 53'($signed({1'b0, i_gain}));
        end
    end

    assign w_sum = 54'(r_prod) + 54'sd8388608;
    assign w_y   = w_sum[53:24];

    always_comb begin
        if (w_y > 30'sd8388607) begin
            o_scaled = 24'sh7FFFFF;
        end else if (w_y < -30'sd8388608) begin
            o_scaled = 24'sh800000;
        end else begin
            o_scaled = w_y[23:0];
        end
    end

endmodule

// ===== hw/rtl/lgn_gain_conv.sv =====
// Correction in 1/64 dB to linear Q4.24 gain, one root product per cycle.
module lgn_gain_conv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lgn_pkg::t_corr i_corr,
    output logic           o_done,
    output lgn_pkg::t_gain o_gain
);
    import lgn_pkg::*;

    localparam logic [1:0] G_IDLE  = 2'd0;
    localparam logic [1:0] G_ITER  = 2'd1;
    localparam logic [1:0] G_FINAL = 2'd2;

    logic [1:0]  r_state;
    logic [36:0] r_exp;
    logic [31:0] r_m;
    logic [4:0]  r_idx;
    logic        r_done;
    t_gain       r_gain;

    logic [31:0] w_root_tab [ROOT_N];
    logic signed [37:0] w_exp;
    logic [23:0] w_frac;
    logic        w_fbit;
    logic [63:0] w_mprod;
    logic [4:0]  w_n;
    logic [4:0]  w_up_sh;
    logic [4:0]  w_dn_sh;
    logic [47:0] w_up;
    logic [32:0] w_rnd;
    logic [32:0] w_dn;
    t_gain       w_gain;

    for (genvar gi = 0; gi < ROOT_N; gi++) begin : g_root
        localparam logic [31:0] RootVal = lgn_root(gi + 1);
        assign w_root_tab[gi] = RootVal;
    end

    // Exponent in signed Q6.32: c * log2(10)/1280 plus a bias of 11.
    assign w_exp = 38'(i_corr) * $signed({14'd0, LOG2_10_STEP})
                   + $signed({2'b0, 4'd11, 32'd0});

    assign w_frac  = r_exp[31:8];
    assign w_fbit  = w_frac[5'd23 - r_idx];
    assign w_mprod = 64'(r_m) * 64'(w_root_tab[r_idx]) + 64'h2000_0000;

    assign w_n     = r_exp[36:32];
    assign w_up_sh = w_n - 5'd17;
    assign w_dn_sh = 5'd17 - w_n;
    assign w_up    = 48'(r_m) << w_up_sh;
    assign w_rnd   = 33'(r_m) + (33'd1 << (w_dn_sh - 5'd1));
    assign w_dn    = w_rnd >> w_dn_sh;

    always_comb begin
        if (w_n >= 5'd17) begin
            w_gain = (w_up > 48'(GAIN_MAX)) ? GAIN_MAX : w_up[GAIN_W-1:0];
        end else begin
            w_gain = (w_dn > 33'(GAIN_MAX)) ? GAIN_MAX : w_dn[GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_state <= G_ITER;
                    end
                end
                G_ITER: begin
                    if (r_idx == 5'(ROOT_N - 1)) begin
                        r_state <= G_FINAL;
                    end
                end
                G_FINAL: begin
                    r_done  <= 1'b1;
                    r_state <= G_IDLE;
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == G_IDLE && i_start) begin
            r_exp <= w_exp[36:0];
            r_m   <= 32'h4000_0000;
            r_idx <= '0;
        end else if (r_state == G_ITER) begin
            if (w_fbit) begin
                r_m <= w_mprod[61:30];
            end
            r_idx <= r_idx + 5'd1;
        end else if (r_state == G_FINAL) begin
            r_gain <= w_gain;
        end
    end

    assign o_done = r_done;
    assign o_gain = r_gain;

endmodule

// ===== hw/rtl/loudness_gain_normalizer.sv =====
// Top level: loudness gain normalizer with smoothing, parallel scaling lanes and merge.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: left, right, loudness; tuser: kind
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: left, right, corr, gain; tuser: audio
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_addr register index, i_cfg_data value
//
// An enabled audio frame steps through accept, the one-pole gain update (ST_SMUL, ST_SUPD),
// the lane multipliers (ST_LMUL) and the merge (ST_OUT). A bypassed frame or a disabled or
// ignored measurement goes from accept straight to the merge. A valid measurement is clamped,
// then runs the 24-step root product loop on the iteration multiplier of the gain converter.
// Reset is synchronous, active low; the smoothed and target gains return to unity.
// Take a new request while a result waits on m_axis; a stalled result holds the merge state.
module loudness_gain_normalizer #(
    parameter int CHANNELS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [23:0] sample_left, [47:24] sample_right,
                                       // [63:48] measured_loudness
    input  logic        s_axis_tuser,  // [0] kind
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // [23:0] out_left, [47:24] out_right,
                                       // [60:48] correction_db, [88:61] correction_gain,
                                       // [95:89] zero
    output logic        m_axis_tuser   // [0] is_audio
);
    import lgn_pkg::*;

    localparam int LANES = (CHANNELS >= 2) ? 2 : 1;

    localparam logic [2:0] CFG_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_TARGET     = 3'd1;
    localparam logic [2:0] CFG_MARGIN     = 3'd2;
    localparam logic [2:0] CFG_MIN_CORR   = 3'd3;
    localparam logic [2:0] CFG_MAX_CORR   = 3'd4;
    localparam logic [2:0] CFG_RAMP_COEFF = 3'd5;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SMUL   = 3'd1;
    localparam logic [2:0] ST_SUPD   = 3'd2;
    localparam logic [2:0] ST_LMUL   = 3'd3;
    localparam logic [2:0] ST_CLAMP  = 3'd4;
    localparam logic [2:0] ST_CSTART = 3'd5;
    localparam logic [2:0] ST_CONV   = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // Configuration registers.
    logic               r_enable;
    logic signed [13:0] r_tgt_loud;
    logic [9:0]         r_margin;
    t_corr              r_min_corr;
    logic [10:0]        r_max_corr;
    logic [23:0]        r_ramp;

    // Block state.
    logic [2:0]  r_state;
    t_gain       r_smoothed;
    t_gain       r_target;
    t_corr       r_applied;

    // Captured request.
    logic        r_is_audio;
    logic        r_bypass;
    t_sample     r_samp_l;
    t_sample     r_samp_r;
    t_loud       r_meas;

    // Smoothing products.
    logic [51:0] r_sa;
    logic [52:0] r_tb;

    // Output register.
    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic        r_out_user;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_in_kind;
    t_loud       w_in_meas;
    logic [53:0] w_acc;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_hi;
    logic signed [17:0] w_clamp;
    logic        w_conv_done;
    t_gain       w_conv_gain;
    t_sample     w_lane_in  [LANES];
    t_sample     w_lane_out [LANES];
    t_sample     w_out_l;
    t_sample     w_out_r;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_kind     = s_axis_tuser;
    assign w_in_meas     = s_axis_tdata[63:48];

    // Register writes; the host must write only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_tgt_loud <= -14'sd1472;
            r_margin   <= '0;
            r_min_corr <= -13'sd1536;
            r_max_corr <= 11'd768;
            r_ramp     <= 24'd16776866;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_ENABLE:     r_enable   <= i_cfg_data[0];
                CFG_TARGET:     r_tgt_loud <= i_cfg_data[13:0];
                CFG_MARGIN:     r_margin   <= i_cfg_data[9:0];
                CFG_MIN_CORR:   r_min_corr <= i_cfg_data[12:0];
                CFG_MAX_CORR:   r_max_corr <= i_cfg_data[10:0];
                CFG_RAMP_COEFF: r_ramp     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // One-pole step: s*a + t*(1 - a), rounded half up back to Q4.24.
    assign w_acc = 54'(r_sa) + 54'(r_tb) + 54'd8388608;

    // Correction = target - margin - measured, clamped; the lower limit wins.
    assign w_diff = 18'(r_tgt_loud) - $signed({8'd0, r_margin}) - 18'(r_meas);
    assign w_hi   = (w_diff > $signed({7'd0, r_max_corr})) ? $signed({7'd0, r_max_corr})
                                                           : w_diff;
    assign w_clamp = (w_hi < 18'(r_min_corr)) ? 18'(r_min_corr) : w_hi;

    lgn_gain_conv u_gain_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_CSTART),
        .i_corr  (r_applied),
        .o_done  (w_conv_done),
        .o_gain  (w_conv_gain)
    );

    // Scaling lanes, one per channel carried.
    assign w_lane_in[0] = r_samp_l;
    if (LANES > 1) begin : g_right_in
        assign w_lane_in[LANES-1] = r_samp_r;
    end

    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        lgn_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (r_state == ST_LMUL),
            .i_sample (w_lane_in[gl]),
            .i_gain   (r_smoothed),
            .o_scaled (w_lane_out[gl])
        );
    end

    // Merge: pick lane results, bypassed samples, or zeros for a measurement.
    always_comb begin
        if (!r_is_audio) begin
            w_out_l = '0;
            w_out_r = '0;
        end else if (r_bypass) begin
            w_out_l = r_samp_l;
            w_out_r = (LANES > 1) ? r_samp_r : '0;
        end else begin
            w_out_l = w_lane_out[0];
            w_out_r = (LANES > 1) ? w_lane_out[LANES-1] : '0;
        end
    end

    // Sequencer and gain state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_smoothed <= UNITY_Q24;
            r_target   <= UNITY_Q24;
            r_applied  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (!w_in_kind) begin
                            r_state <= r_enable ? ST_SMUL : ST_OUT;
                        end else if (!r_enable) begin
                            r_applied <= '0;
                            r_target  <= UNITY_Q24;
                            r_state   <= ST_OUT;
                        end else if (w_in_meas > INVALID_LOUDNESS) begin
                            r_state <= ST_CLAMP;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_SMUL: begin
                    r_state <= ST_SUPD;
                end
                ST_SUPD: begin
                    r_smoothed <= w_acc[51:24];
                    r_state    <= ST_LMUL;
                end
                ST_LMUL: begin
                    r_state <= ST_OUT;
                end
                ST_CLAMP: begin
                    r_applied <= w_clamp[CORR_W-1:0];
                    r_state   <= ST_CSTART;
                end
                ST_CSTART: begin
                    r_state <= ST_CONV;
                end
                ST_CONV: begin
                    if (w_conv_done) begin
                        r_target <= w_conv_gain;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the request and the smoothing products.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_is_audio <= !w_in_kind;
            r_bypass   <= !r_enable;
            r_samp_l   <= s_axis_tdata[23:0];
            r_samp_r   <= s_axis_tdata[47:24];
            r_meas     <= w_in_meas;
        end
        if (r_state == ST_SMUL) begin
            r_sa <= 52'(r_smoothed) * 52'(r_ramp);
            r_tb <= 53'(r_target) * (53'd16777216 - 53'(r_ramp));
        end
    end

    // Output register: load in the merge state, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data <= {7'd0, r_target, r_applied, w_out_r, w_out_l};
            r_out_user <= r_is_audio;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== tb/sv/loudness_gain_normalizer_tb.sv =====
// Self-checking testbench for the loudness gain normalizer: directed table, random phases.
module loudness_gain_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgn_pkg::*;

    localparam int CHANNELS        = 2;
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 8;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 50;
    // A valid measurement runs the whole root product loop; allow a margin after the last result.
    localparam int DRAIN_CYCLES    = 40;
    // Cycles without any accepted request, result or register write before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SAMPLE_MAX      = 8388607;
    localparam int SAMPLE_MIN      = -8388608;

    typedef enum bit {
        KIND_AUDIO   = 1'b0,
        KIND_MEASURE = 1'b1
    } t_kind;

    typedef enum bit [2:0] {
        REG_ENABLE          = 3'd0,
        REG_TARGET_LOUDNESS = 3'd1,
        REG_TARGET_MARGIN   = 3'd2,
        REG_MIN_CORRECTION  = 3'd3,
        REG_MAX_CORRECTION  = 3'd4,
        REG_RAMP_COEFF      = 3'd5
    } t_reg;

    typedef struct packed {
        t_kind   kind;
        t_sample left;
        t_sample right;
        t_loud   loud;
    } t_item;

    typedef struct packed {
        bit      is_audio;
        t_sample left;
        t_sample right;
        t_corr   corr;
        t_gain   gain;
    } t_frame_result;

    // A result typed in by hand travels alongside its request.
    typedef struct packed {
        bit            is_literal;
        t_frame_result res;
    } t_literal_frame;

    typedef struct packed {
        bit            is_cfg;
        t_reg          addr;
        logic [23:0]   data;
        t_item         item;
        bit            is_literal;
        t_frame_result res;
    } t_plan_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr    = '0;
    logic [23:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        m_axis_tuser;

    loudness_gain_normalizer #(
        .CHANNELS(CHANNELS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow copy of the register file, updated on every accepted write.
    bit          cfg_enable = 1'b0;
    int          cfg_target = -1472;
    int          cfg_margin = 0;
    int          cfg_min    = -1536;
    int          cfg_max    = 768;
    logic [23:0] cfg_coeff  = 24'd16776866;

    // Gain state of the block as the predictor sees it.
    t_gain gain_smooth  = UNITY_Q24;
    t_gain gain_target  = UNITY_Q24;
    t_corr corr_applied = '0;

    t_frame_result  pending_frames[$];
    t_literal_frame literal_frames[$];
    int items_sent  = 0;
    int frames_seen = 0;
    int fail_count  = 0;

    // Stimulus knobs: idle percentages per phase; calm turns all idling off.
    bit calm      = 1'b0;
    int gap_pct   = 0;
    int stall_pct = 0;

    bit item_open = 1'b0;
    bit cfg_open  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor square root by setting result bits from the top down.
    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Correction in 1/64 dB to Q4.24 gain: 2^(c*log2(10)/1280), built from a
    // binary fraction times a chain of square roots of two.
    function automatic t_gain corr_to_gain(int c);
        longint      p;
        logic [63:0] e;
        logic [63:0] root;
        logic [63:0] m;
        logic [63:0] g;
        logic [23:0] frac;
        int          n;
        int          sh;
        p    = longint'(c) * longint'(LOG2_10_STEP) + (64'sd11 <<< 32);
        e    = p;
        n    = int'(e[63:32]);
        frac = e[31:8];
        root = 64'd1 << 31;
        m    = 64'd1 << 30;
        for (int i = 1; i <= 24; i++) begin
            root = floor_sqrt(root << 30);
            if (frac[24-i]) begin
                m = (m * root + (64'd1 << 29)) >> 30;
            end
        end
        if (n >= 17) begin
            g = m << (n - 17);
        end else begin
            sh = 17 - n;
            g  = (m + (64'd1 << (sh - 1))) >> sh;
        end
        return (g > 64'(GAIN_MAX)) ? GAIN_MAX : t_gain'(g);
    endfunction

    // Round half up, saturate to 24-bit signed.
    function automatic t_sample scale_sample(t_sample x, t_gain g);
        longint prod;
        longint y;
        prod = longint'(x) * longint'(g);
        y    = (prod + 64'sd8388608) >>> 24;
        if (y > SAMPLE_MAX) begin
            y = SAMPLE_MAX;
        end
        if (y < SAMPLE_MIN) begin
            y = SAMPLE_MIN;
        end
        return t_sample'(y);
    endfunction

    // Advance the gain state by one accepted request and return its result.
    function automatic t_frame_result next_frame_result(t_item it);
        t_frame_result r;
        logic [63:0]   mix;
        int            c;
        r = '0;
        if (it.kind == KIND_AUDIO) begin
            r.is_audio = 1'b1;
            if (cfg_enable) begin
                mix = 64'(gain_smooth) * 64'(cfg_coeff)
                    + 64'(gain_target) * (64'(UNITY_Q24) - 64'(cfg_coeff));
                gain_smooth = t_gain'((mix + 64'h80_0000) >> 24);
                r.left      = scale_sample(it.left, gain_smooth);
                r.right     = (CHANNELS >= 2) ? scale_sample(it.right, gain_smooth) : '0;
            end else begin
                r.left  = it.left;
                r.right = (CHANNELS >= 2) ? it.right : '0;
            end
        end else if (!cfg_enable) begin
            corr_applied = '0;
            gain_target  = UNITY_Q24;
        end else if (int'(it.loud) > int'(INVALID_LOUDNESS)) begin
            c = cfg_target - cfg_margin - int'(it.loud);
            if (c > cfg_max) begin
                c = cfg_max;
            end
            if (c < cfg_min) begin
                c = cfg_min;
            end
            corr_applied = t_corr'(c);
            gain_target  = corr_to_gain(c);
        end
        r.corr = corr_applied;
        r.gain = gain_target;
        return r;
    endfunction

    function automatic void write_shadow(logic [2:0] idx, logic [23:0] v);
        case (t_reg'(idx))
            REG_ENABLE:          cfg_enable = v[0];
            REG_TARGET_LOUDNESS: cfg_target = int'($signed(v[13:0]));
            REG_TARGET_MARGIN:   cfg_margin = int'(v[9:0]);
            REG_MIN_CORRECTION:  cfg_min    = int'($signed(v[12:0]));
            REG_MAX_CORRECTION:  cfg_max    = int'(v[10:0]);
            REG_RAMP_COEFF:      cfg_coeff  = v;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_frame(t_frame_result want);
        if (m_axis_tuser !== want.is_audio) begin
            $error("is_audio: expected %0d, got %0d", want.is_audio, m_axis_tuser);
            fail_count++;
        end
        if (m_axis_tdata[23:0] !== want.left) begin
            $error("out_left: expected %0d, got %0d", want.left, $signed(m_axis_tdata[23:0]));
            fail_count++;
        end
        if (m_axis_tdata[47:24] !== want.right) begin
            $error("out_right: expected %0d, got %0d", want.right,
                   $signed(m_axis_tdata[47:24]));
            fail_count++;
        end
        if (m_axis_tdata[60:48] !== want.corr) begin
            $error("correction_db: expected %0d, got %0d", want.corr,
                   $signed(m_axis_tdata[60:48]));
            fail_count++;
        end
        if (m_axis_tdata[88:61] !== want.gain) begin
            $error("correction_gain: expected %0d, got %0d", want.gain, m_axis_tdata[88:61]);
            fail_count++;
        end
    endtask

    // Check results first, then queue the expectation of a newly accepted request,
    // so a stray result can never match a request taken at the same edge.
    always @(posedge i_clk) begin
        t_item          got;
        t_literal_frame tag;
        t_frame_result  predicted;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                frames_seen++;
                if (pending_frames.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    fail_count++;
                end else begin
                    check_frame(pending_frames.pop_front());
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_shadow(i_cfg_addr, i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got.kind  = t_kind'(s_axis_tuser);
                got.left  = s_axis_tdata[23:0];
                got.right = s_axis_tdata[47:24];
                got.loud  = s_axis_tdata[63:48];
                predicted = next_frame_result(got);
                tag       = literal_frames.pop_front();
                pending_frames.push_back(tag.is_literal ? tag.res : predicted);
            end
        end
    end

    // Hang detection: count edges where nothing moves on any channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: ready drops in bursts of random length
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!calm && int'($urandom_range(0, 99)) < stall_pct) begin
                hold = int'($urandom_range(0, 14));
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, optionally after an idle burst, and hold it until taken.
    task automatic drive_item(t_item it, bit is_literal, t_frame_result res);
        t_literal_frame tag;
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        if (!calm && int'($urandom_range(0, 99)) < gap_pct) begin
            if (item_open) begin
                s_axis_tvalid <= 1'b0;
                item_open = 1'b0;
            end
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.loud, it.right, it.left};
        s_axis_tuser  <= it.kind;
        item_open = 1'b1;
        tag.is_literal = is_literal;
        tag.res        = res;
        literal_frames.push_back(tag);
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Write a register once every outstanding result has come back.
    task automatic write_reg(t_reg r, int v);
        if (item_open) begin
            s_axis_tvalid <= 1'b0;
            item_open = 1'b0;
        end
        while (frames_seen < items_sent) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= r;
        i_cfg_data  <= 24'(v);
        cfg_open = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic t_item mk_item(t_kind k, int l, int r, int loud);
        t_item it;
        it.kind  = k;
        it.left  = t_sample'(l);
        it.right = t_sample'(r);
        it.loud  = t_loud'(loud);
        return it;
    endfunction

    function automatic t_frame_result mk_result(bit audio, int l, int r, int corr, t_gain g);
        t_frame_result res;
        res.is_audio = audio;
        res.left     = t_sample'(l);
        res.right    = t_sample'(r);
        res.corr     = t_corr'(corr);
        res.gain     = g;
        return res;
    endfunction

    function automatic t_plan_row row_cfg(t_reg r, int v);
        t_plan_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.addr   = r;
        row.data   = 24'(v);
        return row;
    endfunction

    function automatic t_plan_row row_item(t_item it);
        t_plan_row row;
        row      = '0;
        row.item = it;
        return row;
    endfunction

    function automatic t_plan_row row_pin(t_item it, t_frame_result res);
        t_plan_row row;
        row            = '0;
        row.item       = it;
        row.is_literal = 1'b1;
        row.res        = res;
        return row;
    endfunction

    // Pick the low end, the high end, or anything in between.
    function automatic int pick_edge(int lo, int hi);
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel < 2) begin
            return lo;
        end
        if (sel < 4) begin
            return hi;
        end
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic t_sample random_sample();
        if ($urandom_range(0, 99) < 20) begin
            case ($urandom_range(0, 3))
                0:       return t_sample'(SAMPLE_MAX);
                1:       return t_sample'(SAMPLE_MIN);
                2:       return '0;
                default: return '1;
            endcase
        end
        return t_sample'($urandom);
    endfunction

    // Mostly loudness readings whose correction lands near the clamp window,
    // with some invalid readings and some raw noise.
    function automatic t_item random_item();
        t_item it;
        int    sel;
        it.kind  = ($urandom_range(0, 99) < 35) ? KIND_MEASURE : KIND_AUDIO;
        it.left  = random_sample();
        it.right = random_sample();
        sel = int'($urandom_range(0, 99));
        if (sel < 60) begin
            it.loud = t_loud'(cfg_target - cfg_margin - (int'($urandom_range(0, 4496)) - 2760));
        end else if (sel < 75) begin
            it.loud = t_loud'(int'(INVALID_LOUDNESS) - int'($urandom_range(0, 19968)));
        end else begin
            it.loud = t_loud'($urandom);
        end
        return it;
    endfunction

    initial begin : stimulus
        t_plan_row     plan[$];
        t_frame_result idle_meas;
        t_frame_result none;
        none      = '0;
        idle_meas = mk_result(1'b0, 0, 0, 0, UNITY_Q24);

        // After reset the block is bypassed: samples pass untouched and a
        // measurement reports zero correction and unity gain.
        plan.push_back(row_pin(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0),
                               mk_result(1'b1, SAMPLE_MAX, SAMPLE_MIN, 0, UNITY_Q24)));
        plan.push_back(row_pin(mk_item(KIND_AUDIO, -1, 0, -1),
                               mk_result(1'b1, -1, 0, 0, UNITY_Q24)));
        plan.push_back(row_pin(mk_item(KIND_MEASURE, SAMPLE_MAX, SAMPLE_MIN, 0), idle_meas));
        plan.push_back(row_cfg(REG_ENABLE, 1));
        // Invalid readings, at the threshold and at the floor, leave unity alone.
        plan.push_back(row_pin(mk_item(KIND_MEASURE, 5, 7, int'(INVALID_LOUDNESS)), idle_meas));
        plan.push_back(row_pin(mk_item(KIND_MEASURE, 0, 0, -32768), idle_meas));
        // Unity target with unity smoothing state: full-scale samples pass exactly.
        plan.push_back(row_pin(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0),
                               mk_result(1'b1, SAMPLE_MAX, SAMPLE_MIN, 0, UNITY_Q24)));
        // Reading equal to target minus margin: zero correction.
        plan.push_back(row_pin(mk_item(KIND_MEASURE, 0, 0, -1472), idle_meas));
        // Just above invalid: clamp to the upper limit; then the other extreme.
        plan.push_back(row_item(mk_item(KIND_MEASURE, 0, 0, int'(INVALID_LOUDNESS) + 1)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, 1, -1, 0)));
        plan.push_back(row_item(mk_item(KIND_MEASURE, 0, 0, 32767)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0)));
        // Widest limits and an instant ramp.
        plan.push_back(row_cfg(REG_TARGET_LOUDNESS, -4480));
        plan.push_back(row_cfg(REG_TARGET_MARGIN, 640));
        plan.push_back(row_cfg(REG_MIN_CORRECTION, -2560));
        plan.push_back(row_cfg(REG_MAX_CORRECTION, 1536));
        plan.push_back(row_cfg(REG_RAMP_COEFF, 0));
        plan.push_back(row_item(mk_item(KIND_MEASURE, 0, 0, int'(INVALID_LOUDNESS) + 1)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, 123456, -654321, 0)));
        plan.push_back(row_item(mk_item(KIND_MEASURE, 0, 0, 32767)));
        plan.push_back(row_item(mk_item(KIND_AUDIO, SAMPLE_MAX, SAMPLE_MIN, 0)));
        // Collapsed window and the slowest ramp.
        plan.push_back(row_cfg(REG_MIN_CORRECTION, 0));
        plan.push_back(row_cfg(REG_MAX_CORRECTION, 0));
        plan.push_back(row_item(mk_item(KIND_MEASURE, 0, 0, -100)));
        plan.push_back(row_cfg(REG_RAMP_COEFF, 16777215));
        plan.push_back(row_item(mk_item(KIND_AUDIO, -4000000, 4000000, 0)));
        // Disabling: a measurement drops back to unity, samples bypass again.
        plan.push_back(row_cfg(REG_ENABLE, 0));
        plan.push_back(row_pin(mk_item(KIND_MEASURE, 0, 0, -100), idle_meas));
        plan.push_back(row_pin(mk_item(KIND_AUDIO, 5, -5, 0),
                               mk_result(1'b1, 5, -5, 0, UNITY_Q24)));

        // Hold reset, then release it at a clock edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_pct   = 20;
        stall_pct = 20;
        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                write_reg(plan[k].addr, int'(plan[k].data));
            end else begin
                drive_item(plan[k].item, plan[k].is_literal, plan[k].res);
            end
        end

        // Random phases: fresh register settings each time, idling varied per
        // phase, and the last phase runs at full rate on both sides.
        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
            write_reg(REG_ENABLE, ($urandom_range(0, 99) < 85) ? 1 : 0);
            write_reg(REG_TARGET_LOUDNESS, pick_edge(-4480, 0));
            write_reg(REG_TARGET_MARGIN, pick_edge(0, 640));
            write_reg(REG_MIN_CORRECTION, pick_edge(-2560, 0));
            write_reg(REG_MAX_CORRECTION, pick_edge(0, 1536));
            case ($urandom_range(0, 3))
                0:       write_reg(REG_RAMP_COEFF, pick_edge(0, 16777215));
                1:       write_reg(REG_RAMP_COEFF, 16776866);
                default: write_reg(REG_RAMP_COEFF, pick_edge(16000000, 16777215));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                drive_item(random_item(), 1'b0, none);
            end
        end

        // Drop valid, wait out the outstanding results, then let the pipeline drain.
        if (item_open) begin
            s_axis_tvalid <= 1'b0;
            item_open = 1'b0;
        end
        while (frames_seen < items_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_frames.size() != 0) begin
            $error("%0d expected results never arrived", pending_frames.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== loudness_gain_normalizer.f =====
hw/rtl/lgn_pkg.sv
hw/rtl/lgn_lane.sv
hw/rtl/lgn_gain_conv.sv
hw/rtl/loudness_gain_normalizer.sv
tb/sv/loudness_gain_normalizer_tb.sv
